// ===== design/lsf_pkg.sv =====
// Shared types and constants for the line substring filter.
// No dependencies; every other file in design/ imports this package.
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int LEN_W       = 5;
  localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
  localparam int BYTE_W      = 8;
  localparam int COL_W       = 16;
  localparam int LINE_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [COL_W-1:0]  COLUMN_SAT   = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] lsf_bytes_t;

  // Active pattern: length already clamped to PATTERN_MAX
  typedef struct packed {
    logic [LEN_W-1:0] len;
    lsf_bytes_t       bytes;
  } lsf_pattern_t;

endpackage

// ===== design/lsf_if.sv =====
// Valid/ready channel interfaces for text bytes in and line results out.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

interface lsf_in_if;
  import lsf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lsf_out_if;
  import lsf_pkg::*;
  logic              valid;
  logic              ready;
  logic              line_matched;
  logic [COL_W-1:0]  match_column;
  logic [LINE_W-1:0] line_number;

  modport source (output valid, output line_matched, output match_column,
                  output line_number, input ready);
  modport sink   (input valid, input line_matched, input match_column,
                  input line_number, output ready);
endinterface

// ===== design/line_substring_filter.sv =====
// Line substring filter top level: config block, history window, line tracker.
// Depends on lsf_pkg, lsf_if, lsf_cfg and lsf_window.
// A line result is registered and appears on out_ch in the cycle after its terminating item.
// Throughput: one text item per cycle; the output register is refilled in the same
//   cycle it is drained, so a stall only holds input while a result is waiting.
// Reset: synchronous active-low rst_n clears config, window, counters and out valid.
`timescale 1ns / 1ps

module line_substring_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  lsf_in_if.sink                         in_ch,
  lsf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsf_pkg::*;

  lsf_pattern_t pattern;
  logic         window_hit;

  // per-line state
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              found_r, found_nxt;
  logic [COL_W-1:0]  first_col_r, first_col_nxt;
  logic [LINE_W-1:0] line_cnt_r;

  // result register
  logic              out_valid_r;
  logic              out_matched_r;
  logic [COL_W-1:0]  out_column_r;
  logic [LINE_W-1:0] out_line_r;

  logic in_accept;
  logic is_newline;
  logic take_byte;   // non-newline item goes into the window
  logic line_done;   // item closes the line and loads a result
  logic col_grown;
  logic new_match;

  lsf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pattern   (pattern)
  );

  lsf_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (take_byte),
    .new_byte   (in_ch.text_byte),
    .pattern    (pattern),
    .window_hit (window_hit)
  );

  // Output register frees when its item is taken, so accept in that same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign is_newline  = (in_ch.text_byte == NEWLINE_BYTE);
  assign take_byte   = in_accept && !is_newline;
  assign line_done   = in_accept && (is_newline || in_ch.end_of_text);

  // Column can still advance on this byte; it saturates at the top.
  assign col_grown = (col_r != COLUMN_SAT);

  always_comb begin
    col_nxt       = col_r;
    found_nxt     = found_r;
    first_col_nxt = first_col_r;
    new_match     = 1'b0;
    if (take_byte) begin
      col_nxt = col_grown ? col_r + COL_W'(1) : col_r;
      // only the first occurrence counts, and only once the line covers the pattern
      new_match = !found_r && (pattern.len != '0) &&
                  (col_nxt >= COL_W'(pattern.len)) && window_hit;
      if (new_match) begin
        found_nxt     = 1'b1;
        first_col_nxt = col_nxt - COL_W'(pattern.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      found_r     <= 1'b0;
      first_col_r <= '0;
      line_cnt_r  <= '0;
    end else if (line_done) begin
      col_r       <= '0;
      found_r     <= 1'b0;
      first_col_r <= '0;
      line_cnt_r  <= line_cnt_r + LINE_W'(1);
    end else begin
      col_r       <= col_nxt;
      found_r     <= found_nxt;
      first_col_r <= first_col_nxt;
    end
  end

  // Empty pattern matches every line at column 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (line_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_done) begin
      out_matched_r <= found_nxt || (pattern.len == '0);
      out_column_r  <= found_nxt ? first_col_nxt : '0;
      out_line_r    <= line_cnt_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.line_matched = out_matched_r;
  assign out_ch.match_column = out_column_r;
  assign out_ch.line_number  = out_line_r;

`ifndef SYNTHESIS
  a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    line_done |=> out_valid_r)
    else $error("line end did not load a result");

  a_line_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    line_done |=> (line_cnt_r == $past(line_cnt_r) + LINE_W'(1)) && (col_r == '0))
    else $error("line counter or column not updated at line end");

  a_column_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (take_byte && !line_done && col_grown) |=> (col_r == $past(col_r) + COL_W'(1)))
    else $error("column did not advance on a text byte");

  a_first_before_col: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (first_col_r < col_r))
    else $error("first match column not below current column");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (first_col_r == '0))
    else $error("match column set without a match");
`endif

endmodule

// ===== design/lsf_cfg.sv =====
// Pattern configuration registers with the length clamp.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,
  output lsf_pkg::lsf_pattern_t          pattern
);
  import lsf_pkg::*;

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] low_r;
  logic [CFG_DATA_W-1:0] high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: len_r  <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_LOW:    low_r  <= cfg_data;
        CFG_PATTERN_HIGH:   high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pattern.len   = (len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_r;
    pattern.bytes = {high_r, low_r};
  end

endmodule

// ===== design/lsf_window.sv =====
// History window of the newest text bytes and the parallel pattern compare.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift_en,
  input  logic [lsf_pkg::BYTE_W-1:0]  new_byte,
  input  lsf_pkg::lsf_pattern_t       pattern,
  output logic                        window_hit
);
  import lsf_pkg::*;

  lsf_bytes_t              hist_r;
  lsf_bytes_t              hist_nxt;
  logic [PATTERN_MAX-1:0]  pos_ok;
  logic [LEN_W-1:0]        pidx;

  // index 0 is the newest byte
  always_comb begin
    hist_nxt = {hist_r[PATTERN_MAX-2:0], new_byte};
  end

  // Window position j holds pattern byte len-1-j; positions past len are don't-care.
  always_comb begin
    pidx = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pidx      = pattern.len - LEN_W'(j) - LEN_W'(1);
      pos_ok[j] = (LEN_W'(j) >= pattern.len) ||
                  (hist_nxt[j] == pattern.bytes[pidx[PAT_IDX_W-1:0]]);
    end
    window_hit = &pos_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (shift_en) begin
      hist_r <= hist_nxt;
    end
  end

endmodule
